// ===== rtl/core/iokvc_pkg.sv =====
// ----------------------------------------------------------------------------
// Insertion-ordered key/value cache package
// Shared constants, operation and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package iokvc_pkg;

    // Field widths fixed by the interface.
    localparam int KEY_W  = 64;
    localparam int VAL_W  = 32;
    localparam int CFG_W  = 7;
    localparam int OP_W   = 2;
    localparam int STAT_W = 3;
    localparam int CTR_W  = 32;

    // Default table depth and the reset value of the occupancy limit.
    localparam int              ENTRIES_DEF   = 64;
    localparam logic [CFG_W-1:0] MAX_ENT_RESET = 7'd64;

    // Operation codes. Code three behaves as a plain lookup.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_EVICTED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_REPLACED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_REFRESHED = 3'd3;
    localparam logic [STAT_W-1:0] ST_MISS      = 3'd4;
    localparam logic [STAT_W-1:0] ST_HIT       = 3'd5;
    localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd6;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_RESOLVE,
        S_SHIFT,
        S_APPEND,
        S_FINISH
    } t_state;

endpackage : iokvc_pkg

`default_nettype wire

// ===== rtl/core/iokvc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port per cycle; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module iokvc_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule : iokvc_ram

`default_nettype wire

// ===== rtl/core/insertion_ordered_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// Insertion-ordered key/value cache
// Fully associative key/value table with first-in-first-out replacement.
// ----------------------------------------------------------------------------
// An operation (insert, lookup, lookup-and-remove) enters on the input channel
// (i_in_valid / o_in_stall) and yields one result on the output channel
// (o_out_valid / i_out_stall); a transaction completes at an edge where valid
// is high and stall is low. Entries sit in one RAM in insertion order, oldest
// at position zero. One key comparator scans P positions (up to the
// occupancy), one per cycle; a removed, evicted or re-inserted entry leaves a
// gap that the M younger entries close, one move per cycle.
// An accepted operation runs through the search, resolve, shift (when entries
// move), append (for an insert) and finish states in that order; an empty
// table skips the search. The longest run is an evicting insert into a full
// table. The input is stalled until the sequencer is back in idle.
// A stalled result waits in the output register while the next operation
// runs; that one then holds in its last cycle until the register frees up.
// Reset empties the table, clears both counters and sets the limit to 64;
// the limit register may be written whenever the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module insertion_ordered_key_value_cache #(
    parameter  int ENTRIES = iokvc_pkg::ENTRIES_DEF,
    localparam int CNT_W   = $clog2(ENTRIES + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Configuration write port
    input  wire logic                         i_cfg_we,
    input  wire logic [iokvc_pkg::CFG_W-1:0]  i_cfg_wdata,
    // Input channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [iokvc_pkg::OP_W-1:0]   i_op,
    input  wire logic [iokvc_pkg::KEY_W-1:0]  i_key,
    input  wire logic [iokvc_pkg::VAL_W-1:0]  i_value_in,
    // Output channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [iokvc_pkg::STAT_W-1:0]      o_status,
    output logic [iokvc_pkg::VAL_W-1:0]       o_value_out,
    output logic [CNT_W-1:0]                  o_occupancy,
    output logic [iokvc_pkg::CTR_W-1:0]       o_access_count,
    output logic [iokvc_pkg::CTR_W-1:0]       o_hit_count
);

    localparam int POS_W = $clog2(ENTRIES);
    localparam int ENT_W = iokvc_pkg::KEY_W + iokvc_pkg::VAL_W;
    localparam int LIM_W = (CNT_W > iokvc_pkg::CFG_W) ? CNT_W : iokvc_pkg::CFG_W;

    // Control registers
    iokvc_pkg::t_state              r_state, n_state;
    logic [CNT_W-1:0]               r_count, n_count;
    logic [iokvc_pkg::CFG_W-1:0]    r_max_entries;
    logic [iokvc_pkg::CTR_W-1:0]    r_search_total, n_search_total;
    logic [iokvc_pkg::CTR_W-1:0]    r_hit_total, n_hit_total;
    logic                           r_out_valid, n_out_valid;
    logic                           r_hit, n_hit;
    logic                           r_append, n_append;
    logic                           r_shift, n_shift;
    logic [CNT_W-1:0]               r_pos, n_pos;

    // Payload registers
    logic [iokvc_pkg::OP_W-1:0]     r_op, n_op;
    logic [iokvc_pkg::KEY_W-1:0]    r_key, n_key;
    logic [iokvc_pkg::VAL_W-1:0]    r_val, n_val;
    logic [iokvc_pkg::VAL_W-1:0]    r_hit_val, n_hit_val;
    logic [iokvc_pkg::VAL_W-1:0]    r_front_val, n_front_val;
    logic [iokvc_pkg::STAT_W-1:0]   r_status, n_status;
    logic [iokvc_pkg::VAL_W-1:0]    r_vout, n_vout;
    logic [iokvc_pkg::STAT_W-1:0]   r_o_status;
    logic [iokvc_pkg::VAL_W-1:0]    r_o_value;
    logic [CNT_W-1:0]               r_o_occupancy;
    logic [iokvc_pkg::CTR_W-1:0]    r_o_access;
    logic [iokvc_pkg::CTR_W-1:0]    r_o_hits;

    // RAM port signals
    logic                           ram_we;
    logic [POS_W-1:0]               ram_waddr;
    logic [ENT_W-1:0]               ram_wdata;
    logic [POS_W-1:0]               ram_raddr;
    logic [ENT_W-1:0]               ram_rdata;
    logic [iokvc_pkg::KEY_W-1:0]    rd_key;
    logic [iokvc_pkg::VAL_W-1:0]    rd_val;

    // Helper signals
    logic                           in_xfer;
    logic                           out_load;
    logic [CNT_W-1:0]               pos_inc;
    logic [CNT_W-1:0]               pos_dec;
    logic [LIM_W-1:0]               max_ext;
    logic [LIM_W-1:0]               lim;
    logic                           evict;

    // Entry storage in insertion order: key in the upper bits, value below.
    iokvc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_key = ram_rdata[ENT_W-1:iokvc_pkg::VAL_W];
    assign rd_val = ram_rdata[iokvc_pkg::VAL_W-1:0];

    assign in_xfer = i_in_valid && (r_state == iokvc_pkg::S_IDLE);
    assign pos_inc = r_pos + CNT_W'(1);
    assign pos_dec = r_pos - CNT_W'(1);

    // Effective occupancy limit: zero acts as one, large values clamp to the depth.
    assign max_ext = LIM_W'(r_max_entries);
    always_comb begin
        if (max_ext == '0) begin
            lim = LIM_W'(1);
        end else if (max_ext > LIM_W'(ENTRIES)) begin
            lim = LIM_W'(ENTRIES);
        end else begin
            lim = max_ext;
        end
    end
    assign evict = (LIM_W'(r_count) >= lim) && (r_count != '0);

    // Sequencer: next state, RAM control and register updates.
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_search_total = r_search_total;
        n_hit_total    = r_hit_total;
        n_hit          = r_hit;
        n_append       = r_append;
        n_shift        = r_shift;
        n_pos          = r_pos;
        n_op           = r_op;
        n_key          = r_key;
        n_val          = r_val;
        n_hit_val      = r_hit_val;
        n_front_val    = r_front_val;
        n_status       = r_status;
        n_vout         = r_vout;
        ram_we         = 1'b0;
        ram_waddr      = pos_dec[POS_W-1:0];
        ram_wdata      = ram_rdata;
        ram_raddr      = r_pos[POS_W-1:0];
        out_load       = 1'b0;
        n_out_valid    = r_out_valid && i_out_stall;

        unique case (r_state)
            iokvc_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_op      = i_op;
                    n_key     = i_key;
                    n_val     = i_value_in;
                    n_hit     = 1'b0;
                    n_pos     = '0;
                    ram_raddr = '0;
                    if (r_search_total != '1) begin
                        n_search_total = r_search_total + iokvc_pkg::CTR_W'(1);
                    end
                    n_state = (r_count == '0) ? iokvc_pkg::S_RESOLVE : iokvc_pkg::S_SEARCH;
                end
            end

            // One order position per cycle through the shared key comparator.
            iokvc_pkg::S_SEARCH: begin
                if (r_pos == '0) begin
                    n_front_val = rd_val;
                end
                if (rd_key == r_key) begin
                    n_hit     = 1'b1;
                    n_hit_val = rd_val;
                    if (r_hit_total != '1) begin
                        n_hit_total = r_hit_total + iokvc_pkg::CTR_W'(1);
                    end
                    n_state = iokvc_pkg::S_RESOLVE;
                end else if (pos_inc == r_count) begin
                    n_state = iokvc_pkg::S_RESOLVE;
                end else begin
                    n_pos     = pos_inc;
                    ram_raddr = pos_inc[POS_W-1:0];
                end
            end

            // Decide the result and which structural update follows.
            iokvc_pkg::S_RESOLVE: begin
                n_shift  = 1'b0;
                n_append = 1'b0;
                if (r_op == iokvc_pkg::OP_INSERT) begin
                    n_append = 1'b1;
                    if (!r_hit) begin
                        n_shift  = evict;
                        n_status = evict ? iokvc_pkg::ST_EVICTED : iokvc_pkg::ST_INSERTED;
                        n_vout   = evict ? r_front_val : r_val;
                    end else begin
                        n_shift  = 1'b1;
                        n_status = (r_hit_val != r_val) ? iokvc_pkg::ST_REPLACED
                                                        : iokvc_pkg::ST_REFRESHED;
                        n_vout   = (r_hit_val != r_val) ? r_hit_val : r_val;
                    end
                end else if (!r_hit) begin
                    n_status = iokvc_pkg::ST_MISS;
                    n_vout   = '0;
                end else begin
                    n_vout = r_hit_val;
                    if (r_op == iokvc_pkg::OP_REMOVE) begin
                        n_shift  = 1'b1;
                        n_status = iokvc_pkg::ST_REMOVED;
                    end else begin
                        n_status = iokvc_pkg::ST_HIT;
                    end
                end
                // The gap opens at the front on eviction, else at the hit position.
                if (r_op == iokvc_pkg::OP_INSERT && !r_hit) begin
                    n_pos = CNT_W'(1);
                end else begin
                    n_pos = pos_inc;
                end
                ram_raddr = n_pos[POS_W-1:0];
                if (n_shift) begin
                    n_state = iokvc_pkg::S_SHIFT;
                end else if (n_append) begin
                    n_state = iokvc_pkg::S_APPEND;
                end else begin
                    n_state = iokvc_pkg::S_FINISH;
                end
            end

            // Move younger entries down one position per cycle.
            iokvc_pkg::S_SHIFT: begin
                if (r_pos < r_count) begin
                    ram_we    = 1'b1;
                    ram_waddr = pos_dec[POS_W-1:0];
                    ram_wdata = ram_rdata;
                    n_pos     = pos_inc;
                    ram_raddr = pos_inc[POS_W-1:0];
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = r_append ? iokvc_pkg::S_APPEND : iokvc_pkg::S_FINISH;
                end
            end

            // Place the inserted entry at the back of the order.
            iokvc_pkg::S_APPEND: begin
                ram_we    = 1'b1;
                ram_waddr = r_count[POS_W-1:0];
                ram_wdata = {r_key, r_val};
                n_count   = r_count + CNT_W'(1);
                n_state   = iokvc_pkg::S_FINISH;
            end

            // Hand the result to the output register once it is free.
            iokvc_pkg::S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = iokvc_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = iokvc_pkg::S_IDLE;
            end
        endcase
    end

    // Control state with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= iokvc_pkg::S_IDLE;
            r_count        <= '0;
            r_max_entries  <= iokvc_pkg::MAX_ENT_RESET;
            r_search_total <= '0;
            r_hit_total    <= '0;
            r_out_valid    <= 1'b0;
            r_hit          <= 1'b0;
            r_append       <= 1'b0;
            r_shift        <= 1'b0;
            r_pos          <= '0;
        end else begin
            r_state        <= n_state;
            r_count        <= n_count;
            r_search_total <= n_search_total;
            r_hit_total    <= n_hit_total;
            r_out_valid    <= n_out_valid;
            r_hit          <= n_hit;
            r_append       <= n_append;
            r_shift        <= n_shift;
            r_pos          <= n_pos;
            if (i_cfg_we) begin
                r_max_entries <= i_cfg_wdata;
            end
        end
    end

    // Operation and result payload.
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_key       <= n_key;
        r_val       <= n_val;
        r_hit_val   <= n_hit_val;
        r_front_val <= n_front_val;
        r_status    <= n_status;
        r_vout      <= n_vout;
        if (out_load) begin
            r_o_status    <= r_status;
            r_o_value     <= r_vout;
            r_o_occupancy <= r_count;
            r_o_access    <= r_search_total;
            r_o_hits      <= r_hit_total;
        end
    end

    // Port drive
    assign o_in_stall     = (r_state != iokvc_pkg::S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_value_out    = r_o_value;
    assign o_occupancy    = r_o_occupancy;
    assign o_access_count = r_o_access;
    assign o_hit_count    = r_o_hits;

`ifndef SYNTH
    // Occupancy never exceeds the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("occupancy above table depth");

    // Hits can never outnumber searches.
    a_hits_le_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit_total <= r_search_total)
        else $error("hit counter above access counter");

    // The scan only looks at occupied positions.
    a_search_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iokvc_pkg::S_SEARCH) |-> (r_pos < r_count))
        else $error("search position beyond occupancy");

    // Occupancy only changes while entries are moved or appended.
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != iokvc_pkg::S_SHIFT && r_state != iokvc_pkg::S_APPEND)
        |=> $stable(r_count))
        else $error("occupancy changed outside an update");

    // An append always finds a free position.
    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iokvc_pkg::S_APPEND) |-> (r_count < CNT_W'(ENTRIES)))
        else $error("append into a full table");
`endif

endmodule : insertion_ordered_key_value_cache

`default_nettype wire
